// ----- hw/rtl/camera_orientation_basis_assert.svh -----
// ----------------------------------------------------------------------------
// camera_orientation_basis_assert.svh
// Assertion macros for the camera orientation basis block. The module that
// uses them provides i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef CAMERA_ORIENTATION_BASIS_ASSERT_SVH
`define CAMERA_ORIENTATION_BASIS_ASSERT_SVH

// Checked out of reset only
`define COB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included
`define COB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/cob_pkg.sv -----
// ----------------------------------------------------------------------------
// cob_pkg
// Shared widths, constants, types and the arctangent table of the camera
// orientation basis block.
// ----------------------------------------------------------------------------
package cob_pkg;

    // Field widths
    localparam int ANGLE_W = 16;
    localparam int VEC_W   = 16;
    localparam int LIMIT_W = 14;
    localparam int Q30_W   = 32;

    // Reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd16202;
    localparam logic [ANGLE_W-1:0] YAW_RESET   = 16'd49152;

    // CORDIC gain 0.6072529350 in Q2.30
    localparam logic signed [Q30_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // Arctangent table, units of 2^-32 turn
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;

    typedef logic signed [Q30_W-1:0] t_q30;
    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [ANGLE_W-1:0] t_angle;

    localparam t_q30 ATAN_TAB [ATAN_LEN] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
    };

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROT,
        ST_QUAD,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/cob_in_if.sv -----
// ----------------------------------------------------------------------------
// cob_in_if
// Input channel: one angle update per transfer.
// ----------------------------------------------------------------------------
interface cob_in_if;
    logic                 valid;
    logic                 ready;
    logic                 func;
    cob_pkg::t_angle      delta;

    modport source (output valid, output func, output delta, input ready);
    modport sink   (input valid, input func, input delta, output ready);
endinterface

// ----- hw/rtl/cob_out_if.sv -----
// ----------------------------------------------------------------------------
// cob_out_if
// Output channel: front, right and up vectors in Q1.15 per transfer.
// ----------------------------------------------------------------------------
interface cob_out_if;
    logic           valid;
    logic           ready;
    cob_pkg::t_vec  front_x;
    cob_pkg::t_vec  front_y;
    cob_pkg::t_vec  front_z;
    cob_pkg::t_vec  right_x;
    cob_pkg::t_vec  right_z;
    cob_pkg::t_vec  up_x;
    cob_pkg::t_vec  up_y;
    cob_pkg::t_vec  up_z;

    modport source (
        output valid, output front_x, output front_y, output front_z,
        output right_x, output right_z, output up_x, output up_y, output up_z,
        input ready
    );
    modport sink (
        input valid, input front_x, input front_y, input front_z,
        input right_x, input right_z, input up_x, input up_y, input up_z,
        output ready
    );
endinterface

// ----- hw/rtl/camera_orientation_basis.sv -----
// Input ready only when idle: a new item is taken only after the last result has
// been loaded into the output register. A single CORDIC stage serves both passes
// (one step per cycle, yaw then pitch), and a single 32x32 multiplier forms the
// four products in turn.
// Reset (synchronous, active low): yaw -90 deg, pitch 0, limit 89 deg, no result held.
// ----------------------------------------------------------------------------
// camera_orientation_basis
// Yaw/pitch camera orientation: accumulates angle deltas, then computes the
// front, right and up unit vectors with an iterative CORDIC and one multiplier.
// ----------------------------------------------------------------------------
`include "camera_orientation_basis_assert.svh"

module camera_orientation_basis #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cob_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    cob_in_if.sink                            i_in,
    cob_out_if.source                         o_out
);

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam int AIW = cob_pkg::ATAN_IDX_W;
    localparam int MUL_W = 3;
    localparam logic [MUL_W-1:0] MUL_LAST = 3'd4;

    // Saturate a 20-bit rounded value to Q1.15
    function automatic cob_pkg::t_vec sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'sd32767;
        end else if (v < -20'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    // Round a Q2.30 value to Q1.15
    function automatic cob_pkg::t_vec round_q15(input logic signed [32:0] v);
        logic signed [32:0] sum;
        sum = v + 33'sd16384;
        return sat16(20'(sum >>> 15));
    endfunction

    // Round a Q4.60 product to Q1.15
    function automatic cob_pkg::t_vec round_prod(input logic signed [63:0] p);
        logic signed [64:0] sum;
        sum = {p[63], p} + (65'sd1 <<< 44);
        return sat16(sum[64:45]);
    endfunction

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    cob_pkg::t_state              r_state, n_state;
    logic [cob_pkg::LIMIT_W-1:0]  r_limit;
    logic [cob_pkg::ANGLE_W-1:0]  r_yaw;
    cob_pkg::t_angle              r_pitch;
    logic                         r_pass;
    logic [STEP_W-1:0]            r_step;
    logic [MUL_W-1:0]             r_mul;
    logic [1:0]                   r_quad;
    cob_pkg::t_q30                r_x, r_y, r_z;
    cob_pkg::t_q30                r_cy, r_sy, r_cp, r_sp;
    logic signed [63:0]           r_prod;
    cob_pkg::t_vec                r_fx, r_fz, r_ux, r_uz;
    logic                         r_out_valid;
    cob_pkg::t_vec                r_o_fx, r_o_fy, r_o_fz, r_o_rx, r_o_rz;
    cob_pkg::t_vec                r_o_ux, r_o_uy, r_o_uz;

    logic in_xfer;
    logic load_out;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cob_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            cob_pkg::ST_IDLE: begin
                if (i_in.valid) n_state = cob_pkg::ST_LOAD;
            end
            cob_pkg::ST_LOAD: begin
                n_state = cob_pkg::ST_ROT;
            end
            cob_pkg::ST_ROT: begin
                if (r_step == STEP_LAST) n_state = cob_pkg::ST_QUAD;
            end
            cob_pkg::ST_QUAD: begin
                n_state = r_pass ? cob_pkg::ST_MUL : cob_pkg::ST_LOAD;
            end
            cob_pkg::ST_MUL: begin
                if (r_mul == MUL_LAST) n_state = cob_pkg::ST_DONE;
            end
            cob_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = cob_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cob_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_in.ready = (r_state == cob_pkg::ST_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------------
    // Angle state and limit register
    // ------------------------------------------------------------------------
    logic signed [16:0] pitch_sum;
    logic signed [16:0] lim_ext;
    logic signed [16:0] pitch_clamped;

    always_comb begin
        pitch_sum = {r_pitch[15], r_pitch} + {i_in.delta[15], i_in.delta};
        lim_ext   = $signed({3'b000, r_limit});
        pitch_clamped = pitch_sum;
        if (pitch_sum > lim_ext) pitch_clamped = lim_ext;
        if (pitch_sum < -lim_ext) pitch_clamped = -lim_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= cob_pkg::LIMIT_RESET;
            r_yaw   <= cob_pkg::YAW_RESET;
            r_pitch <= '0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (in_xfer) begin
                if (!i_in.func) begin
                    r_yaw <= r_yaw + i_in.delta;
                end else begin
                    r_pitch <= pitch_clamped[15:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Quadrant reduction of the angle for the current pass
    // ------------------------------------------------------------------------
    logic [cob_pkg::ANGLE_W-1:0] ang;
    logic [cob_pkg::ANGLE_W-1:0] ang_bias;
    logic [1:0]                  quad;
    logic [cob_pkg::ANGLE_W-1:0] ang_rem;

    always_comb begin
        ang      = r_pass ? r_pitch : r_yaw;
        ang_bias = ang + 16'd8192;
        quad     = ang_bias[15:14];
        ang_rem  = ang - {quad, 14'd0};
    end

    // ------------------------------------------------------------------------
    // CORDIC step (shared shifter and adders)
    // ------------------------------------------------------------------------
    cob_pkg::t_q30 x_sh, y_sh, atan_val;

    always_comb begin
        x_sh     = r_x >>> r_step;
        y_sh     = r_y >>> r_step;
        atan_val = cob_pkg::ATAN_TAB[AIW'(r_step)];
    end

    // ------------------------------------------------------------------------
    // Multiplier operand select
    // ------------------------------------------------------------------------
    cob_pkg::t_q30 mul_a, mul_b;

    always_comb begin
        case (r_mul[1:0])
            2'd0: begin mul_a = r_cy;  mul_b = r_cp; end
            2'd1: begin mul_a = r_sy;  mul_b = r_cp; end
            2'd2: begin mul_a = -r_cy; mul_b = r_sp; end
            default: begin mul_a = -r_sy; mul_b = r_sp; end
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= 1'b0;
            r_step <= '0;
            r_mul  <= '0;
        end else begin
            if (in_xfer) r_pass <= 1'b0;
            if (r_state == cob_pkg::ST_LOAD) r_step <= '0;
            if (r_state == cob_pkg::ST_ROT) begin
                r_step <= (r_step == STEP_LAST) ? '0 : r_step + 1'b1;
            end
            if (r_state == cob_pkg::ST_QUAD) begin
                r_pass <= ~r_pass;
                r_mul  <= '0;
            end
            if (r_state == cob_pkg::ST_MUL) r_mul <= r_mul + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        // start a rotation
        if (r_state == cob_pkg::ST_LOAD) begin
            r_quad <= quad;
            r_x    <= cob_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= $signed({ang_rem, 16'd0});
        end
        // one micro-rotation
        if (r_state == cob_pkg::ST_ROT) begin
            if (!r_z[31]) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_val;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_val;
            end
        end
        // apply quadrant, keep cos/sin of this pass
        if (r_state == cob_pkg::ST_QUAD) begin
            case (r_quad)
                2'd0: begin
                    if (r_pass) begin r_cp <= r_x;  r_sp <= r_y;  end
                    else        begin r_cy <= r_x;  r_sy <= r_y;  end
                end
                2'd1: begin
                    if (r_pass) begin r_cp <= -r_y; r_sp <= r_x;  end
                    else        begin r_cy <= -r_y; r_sy <= r_x;  end
                end
                2'd2: begin
                    if (r_pass) begin r_cp <= -r_x; r_sp <= -r_y; end
                    else        begin r_cy <= -r_x; r_sy <= -r_y; end
                end
                default: begin
                    if (r_pass) begin r_cp <= r_y;  r_sp <= -r_x; end
                    else        begin r_cy <= r_y;  r_sy <= -r_x; end
                end
            endcase
        end
        // product registered, rounding in the next cycle
        if (r_state == cob_pkg::ST_MUL) begin
            r_prod <= mul_a * mul_b;
            case (r_mul)
                3'd1: r_fx <= round_prod(r_prod);
                3'd2: r_fz <= round_prod(r_prod);
                3'd3: r_ux <= round_prod(r_prod);
                3'd4: r_uz <= round_prod(r_prod);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_fx <= r_fx;
            r_o_fy <= round_q15({r_sp[31], r_sp});
            r_o_fz <= r_fz;
            r_o_rx <= round_q15(-$signed({r_sy[31], r_sy}));
            r_o_rz <= round_q15({r_cy[31], r_cy});
            r_o_ux <= r_ux;
            r_o_uy <= round_q15({r_cp[31], r_cp});
            r_o_uz <= r_uz;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.front_x = r_o_fx;
    assign o_out.front_y = r_o_fy;
    assign o_out.front_z = r_o_fz;
    assign o_out.right_x = r_o_rx;
    assign o_out.right_z = r_o_rz;
    assign o_out.up_x    = r_o_ux;
    assign o_out.up_y    = r_o_uy;
    assign o_out.up_z    = r_o_uz;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `COB_ASSERT(a_xfer_starts, in_xfer |=> r_state == cob_pkg::ST_LOAD, "transfer did not start a pass")
    `COB_ASSERT(a_pitch_range, (r_pitch >= -16'sd16383) && (r_pitch <= 16'sd16383), "pitch out of range")
    `COB_ASSERT(a_step_range, r_step <= STEP_LAST, "CORDIC step counter out of range")
    `COB_ASSERT(a_done_holds, (r_state == cob_pkg::ST_DONE) && r_out_valid && !o_out.ready |=> r_state == cob_pkg::ST_DONE, "result dropped while output stalled")
    `COB_ASSERT_ALWAYS(a_reset, !i_rst_n |=> (r_state == cob_pkg::ST_IDLE) && !r_out_valid, "reset did not clear control")

endmodule

// ----- verif/camera_orientation_basis_tb.sv -----
// ----------------------------------------------------------------------------
// camera_orientation_basis_tb
// Self-checking bench for the yaw/pitch camera basis block. A directed table
// covers wrap, clamp and limit corners, then random angle updates run across
// several pitch limits. Every result transfer is checked field by field
// against a bit-exact CORDIC predictor in the bench or a hand-written value.
// ----------------------------------------------------------------------------
module camera_orientation_basis_tb;

    localparam int STEPS         = 16;
    localparam int SETTLE_CYCLES = 2*STEPS + 12;
    localparam int QUIET_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int PHASES        = 6;
    localparam int REPORT_MAX    = 10;
    localparam int N_ROWS        = 27;

    // Item operations
    localparam logic FUNC_YAW   = 1'b0;
    localparam logic FUNC_PITCH = 1'b1;

    // Saturated and zero Q1.15 values
    localparam logic [cob_pkg::VEC_W-1:0] Q15_MAX  = 16'h7FFF;
    localparam logic [cob_pkg::VEC_W-1:0] Q15_MIN  = 16'h8000;
    localparam logic [cob_pkg::VEC_W-1:0] Q15_ZERO = 16'h0000;

    typedef enum logic {ROW_ITEM, ROW_LIMIT} t_row_kind;

    // front_x, front_y, front_z, right_x, right_z, up_x, up_y, up_z
    typedef logic [0:7][cob_pkg::VEC_W-1:0] t_basis;

    typedef struct {
        t_row_kind          kind;
        logic               func;
        logic [15:0]        arg;    // delta, or the new limit
        logic [0:7]         care;   // fields with a hand-written value
        t_basis             typed;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [cob_pkg::LIMIT_W-1:0]    cfg_wdata;

    cob_in_if  in_ch ();
    cob_out_if out_ch ();

    camera_orientation_basis #(
        .CORDIC_STEPS(STEPS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Shadow camera state
    logic [cob_pkg::ANGLE_W-1:0] yaw_acc;
    int                          pitch_acc;
    int                          limit_reg;

    t_basis pending_basis [$];
    int     fail_count = 0;
    int     quiet_cycles = 0;
    int     burst_left;
    t_row   dir_rows [N_ROWS];
    string  field_name [0:7] = '{"front_x", "front_y", "front_z", "right_x",
                                 "right_z", "up_x", "up_y", "up_z"};

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sine and cosine of a 16-bit angle in Q2.30
    task automatic cordic_sincos(input logic [cob_pkg::ANGLE_W-1:0] ang,
                                 output longint c, output longint s);
        logic [cob_pkg::ANGLE_W-1:0] shifted;
        logic [cob_pkg::ANGLE_W-1:0] rem;
        logic [1:0]                  quad;
        longint                      x, y, z, nx;
        int                          i;
        shifted = ang + 16'd8192;
        quad    = shifted[15:14];
        rem     = ang - {quad, 14'd0};
        x = longint'(cob_pkg::CORDIC_GAIN);
        y = 0;
        z = longint'($signed(rem)) * 65536;
        for (i = 0; i < STEPS && i < cob_pkg::ATAN_LEN; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(cob_pkg::ATAN_TAB[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(cob_pkg::ATAN_TAB[i]);
            end
            x = nx;
        end
        // fold the quadrant back in
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic [cob_pkg::VEC_W-1:0] q15_sat(input longint v);
        if (v > 32767)
            return Q15_MAX;
        if (v < -32768)
            return Q15_MIN;
        return v[15:0];
    endfunction

    function automatic logic [cob_pkg::VEC_W-1:0] q15_round(input longint v);
        return q15_sat((v + 64'sd16384) >>> 15);
    endfunction

    function automatic logic [cob_pkg::VEC_W-1:0] q15_product(input longint a,
                                                               input longint b);
        longint p;
        p = a * b + (64'sd1 <<< 44);
        return q15_sat(p >>> 45);
    endfunction

    // Apply one angle update and return the new basis
    task automatic predict_basis(input logic fn, input logic [cob_pkg::ANGLE_W-1:0] dl,
                                 output t_basis r);
        longint cy, sy, cp, sp;
        int     p;
        if (fn == FUNC_YAW) begin
            yaw_acc = yaw_acc + dl;
        end else begin
            p = pitch_acc + int'($signed(dl));
            if (p > limit_reg)
                p = limit_reg;
            if (p < -limit_reg)
                p = -limit_reg;
            pitch_acc = p;
        end
        cordic_sincos(yaw_acc, cy, sy);
        cordic_sincos(pitch_acc[15:0], cp, sp);
        r[0] = q15_product(cy, cp);
        r[1] = q15_round(sp);
        r[2] = q15_product(sy, cp);
        r[3] = q15_round(-sy);
        r[4] = q15_round(cy);
        r[5] = q15_product(-cy, sp);
        r[6] = q15_round(cp);
        r[7] = q15_product(-sy, sp);
    endtask

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // One input transfer, with bursty gaps ahead of it
    task automatic send_item(input logic fn, input logic [cob_pkg::ANGLE_W-1:0] dl,
                             input logic [0:7] care, input t_basis typed);
        int     gap;
        int     f;
        t_basis want;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.func  <= fn;
        in_ch.delta <= dl;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        predict_basis(fn, dl, want);
        for (f = 0; f < 8; f++) begin
            if (care[f])
                want[f] = typed[f];
        end
        pending_basis.push_back(want);
    endtask

    // Hold off the sender until every pending result has been transferred
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_basis.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_limit(input logic [cob_pkg::LIMIT_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        limit_reg = int'(value);
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [cob_pkg::ANGLE_W-1:0] random_delta();
        logic [cob_pkg::ANGLE_W-1:0] d;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: d = 16'(int'($urandom_range(0, 2047)) - 1024);
            6, 7:             d = 16'(int'($urandom_range(0, 16383)) - 8192);
            8:                d = 16'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0:       d = 16'h8000;
                    1:       d = 16'h7FFF;
                    2:       d = 16'h0000;
                    3:       d = 16'h0001;
                    default: d = 16'hFFFF;
                endcase
            end
        endcase
        return d;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_basis got;
        t_basis want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.front_x, out_ch.front_y, out_ch.front_z, out_ch.right_x,
                   out_ch.right_z, out_ch.up_x, out_ch.up_y, out_ch.up_z};
            if (pending_basis.size() == 0) begin
                log_failure("result transfer with no expectation pending");
            end else begin
                want = pending_basis.pop_front();
                for (int f = 0; f < 8; f++) begin
                    if (got[f] !== want[f])
                        log_failure($sformatf("%s expected %0d, got %0d", field_name[f],
                                              $signed(want[f]), $signed(got[f])));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver stalls follow a rotating mask that is redrawn now and then
    initial begin
        logic [15:0] stall_mask;
        int          hold;
        out_ch.ready = 1'b0;
        stall_mask   = 16'hFFFF;
        hold         = 0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                hold = $urandom_range(64, 400);
                case ($urandom_range(0, 3))
                    0:       stall_mask = 16'hFFFF;
                    1:       stall_mask = 16'($urandom);
                    2:       stall_mask = 16'h0001 << $urandom_range(0, 15);
                    default: stall_mask = 16'($urandom) | 16'($urandom);
                endcase
                if (stall_mask == 16'h0000)
                    stall_mask = 16'h0001;
            end
            hold--;
            out_ch.ready <= stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[15:1]};
        end
    end

    // Stimulus
    initial begin
        logic [cob_pkg::LIMIT_W-1:0] lim;
        int                          phase;
        int                          n;
        t_basis                      no_typed;
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_ch.valid = 1'b0;
        in_ch.func  = FUNC_YAW;
        in_ch.delta = '0;
        yaw_acc     = cob_pkg::YAW_RESET;
        pitch_acc   = 0;
        limit_reg   = int'(cob_pkg::LIMIT_RESET);
        burst_left  = 0;
        no_typed    = '0;

        // Directed corners; typed values only where the result is saturated or zero
        dir_rows = '{
            // reset pose: yaw -90 deg, pitch 0
            '{ROW_ITEM, FUNC_YAW, 16'h0000, 8'b00110110,
              {Q15_ZERO, Q15_ZERO, Q15_MIN, Q15_MAX, Q15_ZERO, Q15_ZERO, Q15_MAX, Q15_ZERO}},
            // yaw to 0
            '{ROW_ITEM, FUNC_YAW, 16'h4000, 8'b10001011,
              {Q15_MAX, Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_MAX, Q15_ZERO, Q15_MAX, Q15_ZERO}},
            // pitch clamps high, then low, then back to level
            '{ROW_ITEM, FUNC_PITCH, 16'h7FFF, 8'b0, '0},
            '{ROW_ITEM, FUNC_PITCH, 16'h8000, 8'b0, '0},
            '{ROW_ITEM, FUNC_PITCH, 16'h3F4A, 8'b10001011,
              {Q15_MAX, Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_MAX, Q15_ZERO, Q15_MAX, Q15_ZERO}},
            // yaw to 180 deg
            '{ROW_ITEM, FUNC_YAW, 16'h8000, 8'b10001011,
              {Q15_MIN, Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_MIN, Q15_ZERO, Q15_MAX, Q15_ZERO}},
            // yaw wraps through a full turn back to 0
            '{ROW_ITEM, FUNC_YAW, 16'h7FFF, 8'b0, '0},
            '{ROW_ITEM, FUNC_YAW, 16'h0001, 8'b10001011,
              {Q15_MAX, Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_MAX, Q15_ZERO, Q15_MAX, Q15_ZERO}},
            '{ROW_ITEM, FUNC_PITCH, 16'h5555, 8'b0, '0},
            '{ROW_ITEM, FUNC_PITCH, 16'hAAAA, 8'b0, '0},
            '{ROW_ITEM, FUNC_YAW, 16'h5555, 8'b0, '0},
            '{ROW_ITEM, FUNC_YAW, 16'hAAAA, 8'b0, '0},
            '{ROW_ITEM, FUNC_PITCH, 16'h0001, 8'b0, '0},
            '{ROW_ITEM, FUNC_PITCH, 16'hFFFF, 8'b0, '0},
            // quadrant boundaries
            '{ROW_ITEM, FUNC_YAW, 16'h2000, 8'b0, '0},
            '{ROW_ITEM, FUNC_YAW, 16'hDFFF, 8'b0, '0},
            // zero limit pins pitch level
            '{ROW_LIMIT, FUNC_YAW, 16'h0000, 8'b0, '0},
            '{ROW_ITEM, FUNC_PITCH, 16'h03E8, 8'b00000010,
              {Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_MAX, Q15_ZERO}},
            '{ROW_ITEM, FUNC_PITCH, 16'h8000, 8'b00000010,
              {Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_MAX, Q15_ZERO}},
            // widest limit, both ends
            '{ROW_LIMIT, FUNC_YAW, 16'h3FFF, 8'b0, '0},
            '{ROW_ITEM, FUNC_PITCH, 16'h7FFF, 8'b0, '0},
            '{ROW_ITEM, FUNC_PITCH, 16'h8000, 8'b0, '0},
            '{ROW_ITEM, FUNC_YAW, 16'h0000, 8'b0, '0},
            // tighter limit: yaw leaves pitch alone, next pitch item clamps
            '{ROW_LIMIT, FUNC_YAW, 16'h0064, 8'b0, '0},
            '{ROW_ITEM, FUNC_YAW, 16'h0064, 8'b0, '0},
            '{ROW_ITEM, FUNC_PITCH, 16'h0000, 8'b0, '0},
            '{ROW_LIMIT, FUNC_YAW, 16'h3F4A, 8'b0, '0}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_LIMIT)
                write_limit(dir_rows[r].arg[cob_pkg::LIMIT_W-1:0]);
            else
                send_item(dir_rows[r].func, dir_rows[r].arg, dir_rows[r].care,
                          dir_rows[r].typed);
        end

        // Random updates, one pitch limit per phase
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       lim = 14'h3FFF;
                1:       lim = 14'h0000;
                2:       lim = 14'($urandom_range(1, 16382));
                3:       lim = cob_pkg::LIMIT_RESET;
                4:       lim = 14'h0001;
                default: lim = 14'($urandom_range(0, 16383));
            endcase
            write_limit(lim);
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if (phase == 2 && n == RANDOM_ITEMS / PHASES / 2)
                    drain_results();
                send_item(1'($urandom_range(0, 1)), random_delta(), 8'b0, no_typed);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_basis.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/cob_pkg.sv
hw/rtl/cob_in_if.sv
hw/rtl/cob_out_if.sv
hw/rtl/camera_orientation_basis.sv
verif/camera_orientation_basis_tb.sv
